// ===== rtl/core/sdft_pkg.sv =====
// shared types and constants of the single-bin sliding dft
package sdft_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int TW_W = 16;
	localparam int SUM_W = 32;
	localparam int MAG_W = 33;
	localparam int MAX_CHANNELS = 4;

	// build defaults
	localparam int DEF_WINDOW_LENGTH = 64;
	localparam int DEF_BIN_INDEX = 8;
	localparam int DEF_NUM_CHANNELS = 4;
	localparam int DEF_SAMPLE_BITS = 16;

	// command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_PURGE = 1'b1;

	// input transaction
	typedef struct packed {
		logic command;
		logic signed [SAMPLE_W-1:0] sample_0;
		logic signed [SAMPLE_W-1:0] sample_1;
		logic signed [SAMPLE_W-1:0] sample_2;
		logic signed [SAMPLE_W-1:0] sample_3;
	} sample_t;

	// output transaction
	typedef struct packed {
		logic signed [SUM_W-1:0] real_0;
		logic signed [SUM_W-1:0] real_1;
		logic signed [SUM_W-1:0] real_2;
		logic signed [SUM_W-1:0] real_3;
		logic signed [SUM_W-1:0] imag_0;
		logic signed [SUM_W-1:0] imag_1;
		logic signed [SUM_W-1:0] imag_2;
		logic signed [SUM_W-1:0] imag_3;
		logic [MAG_W-1:0] magnitude_0;
		logic [MAG_W-1:0] magnitude_1;
		logic [MAG_W-1:0] magnitude_2;
		logic [MAG_W-1:0] magnitude_3;
	} result_t;

	// per-cycle control handed from the sequencer to every lane
	typedef struct packed {
		logic load;    // sample transaction accepted: write ring, load stage 1
		logic update;  // stage 1 moves into the running sums
		logic clear;   // stage 1 holds a purge
		logic filled;  // ring slot of stage 1 was written since the last purge
	} lane_ctrl_t;

endpackage

// ===== rtl/core/sliding_dft_single_bin.sv =====
// top level of the multichannel single-bin sliding dft
//
//   channel   direction   handshake                    payload
//   sample    in          sample_valid / sample_stall  sample_t (command, samples)
//   result    out         result_valid / result_stall  result_t (re, im, magnitude)
//
// one transaction per cycle sustained while result_stall is low; each sample transaction
// passes the ring read, the sum update and the magnitude into the output register.
// the rate is set by the per-lane product ring, read and written once per cycle.
// reset clears sums, ring position and the fill flag at once; no clearing pass.
// an output stall holds the output register; bubbles inside still close up, and
// sample_stall rises only once every stage is occupied.
module sliding_dft_single_bin import sdft_pkg::*; #(
	parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
	parameter int BIN_INDEX = DEF_BIN_INDEX,
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  sample_t sample,
	output logic result_valid,
	input  logic result_stall,
	output result_t result
);

	localparam int PosW = $clog2(WINDOW_LENGTH);

	logic accept;
	logic en2;
	logic en3;
	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic clear_s1;
	logic filled_s1;
	logic filled_q;
	logic [PosW-1:0] pos_q;
	logic signed [TW_W-1:0] tw_re;
	logic signed [TW_W-1:0] tw_im;
	logic signed [SAMPLE_W-1:0] samples [MAX_CHANNELS];
	logic signed [SUM_W-1:0] real_sum [MAX_CHANNELS];
	logic signed [SUM_W-1:0] imag_sum [MAX_CHANNELS];
	lane_ctrl_t lane_ctrl;

	// pipeline flow: each stage moves when the one after it has room
	assign en3 = !v3_q || !result_stall;
	assign en2 = !v2_q || en3;
	assign sample_stall = v1_q && !en2;
	assign accept = sample_valid && !sample_stall;
	assign result_valid = v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (!sample_stall) begin
				v1_q <= sample_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	// ring position and fill flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			filled_q <= 1'b0;
		end else if (accept) begin
			if (sample.command == CMD_PURGE) begin
				pos_q <= '0;
				filled_q <= 1'b0;
			end else if (pos_q == PosW'(WINDOW_LENGTH - 1)) begin
				pos_q <= '0;
				filled_q <= 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_s1 <= 1'b0;
			filled_s1 <= 1'b0;
		end else if (accept) begin
			clear_s1 <= (sample.command == CMD_PURGE);
			filled_s1 <= filled_q;
		end
	end

	assign lane_ctrl.load = accept && (sample.command == CMD_SAMPLE);
	assign lane_ctrl.update = v1_q && en2;
	assign lane_ctrl.clear = clear_s1;
	assign lane_ctrl.filled = filled_s1;

	assign samples[0] = sample.sample_0;
	assign samples[1] = sample.sample_1;
	assign samples[2] = sample.sample_2;
	assign samples[3] = sample.sample_3;

	// shared twiddle lookup
	sdft_twiddle #(
		.WINDOW_LENGTH(WINDOW_LENGTH),
		.BIN_INDEX(BIN_INDEX)
	) u_twiddle (
		.pos(pos_q),
		.tw_re(tw_re),
		.tw_im(tw_im)
	);

	// lanes for active channels, zero for the rest
	for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
		if (c < NUM_CHANNELS) begin : g_on
			sdft_lane #(
				.WINDOW_LENGTH(WINDOW_LENGTH),
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_lane (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(lane_ctrl),
				.pos(pos_q),
				.sample(samples[c]),
				.tw_re(tw_re),
				.tw_im(tw_im),
				.real_sum(real_sum[c]),
				.imag_sum(imag_sum[c])
			);
		end else begin : g_off
			assign real_sum[c] = '0;
			assign imag_sum[c] = '0;
		end
	end

	sdft_merge u_merge (
		.clk(clk),
		.load(v2_q && en3),
		.real_sum(real_sum),
		.imag_sum(imag_sum),
		.result(result)
	);

endmodule

// ===== rtl/core/sdft_twiddle.sv =====
// constant twiddle rom indexed by ring position, built at elaboration
module sdft_twiddle import sdft_pkg::*; #(
	parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
	parameter int BIN_INDEX = DEF_BIN_INDEX,
	localparam int PosW = $clog2(WINDOW_LENGTH)
) (
	input  logic [PosW-1:0] pos,
	output logic signed [TW_W-1:0] tw_re,
	output logic signed [TW_W-1:0] tw_im
);

	localparam logic [63:0] WinLen = 64'(WINDOW_LENGTH);
	localparam logic [63:0] BinIdx = 64'(BIN_INDEX);
	localparam logic [63:0] HalfPiQ62 = 64'h6487ED5110B4611A;
	localparam logic [63:0] OneQ62 = 64'h4000000000000000;
	localparam logic [63:0] CosDiv [14] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756};
	localparam logic [63:0] SinDiv [14] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812};

	// q62 product, bits 125..62 of the full product
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// truncate 32767 * v toward zero, v in q62 within [0,1]
	function automatic int q62_to_q15(input logic [63:0] v);
		logic [63:0] h;
		logic [63:0] l;
		logic [63:0] r;
		h = v >> 31;
		l = v & 64'h7FFFFFFF;
		r = (h * 64'd32767 + ((l * 64'd32767) >> 31)) >> 31;
		return (r > 64'd32767) ? 32767 : int'(r[15:0]);
	endfunction

	// {re, im} twiddle word for ring position n
	function automatic logic [2*TW_W-1:0] twiddle_word(input int n);
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] theta;
		logic [63:0] t2;
		logic [63:0] tc;
		logic [63:0] ts;
		logic [63:0] sc;
		logic [63:0] ss;
		int cq;
		int sq;
		int cv;
		int sv;
		m = (64'(n) * BinIdx) % WinLen;
		q = (64'd4 * m) / WinLen;
		r = (64'd4 * m) % WinLen;
		if (r == 64'd0) begin
			cq = 32767;
			sq = 0;
		end else begin
			theta = (HalfPiQ62 / WinLen) * r + ((HalfPiQ62 % WinLen) * r) / WinLen;
			t2 = q62_mul(theta, theta);
			tc = OneQ62;
			ts = theta;
			sc = OneQ62;
			ss = theta;
			// taylor series, alternating terms
			for (int i = 0; i < 14; i++) begin
				tc = q62_mul(tc, t2) / CosDiv[i];
				ts = q62_mul(ts, t2) / SinDiv[i];
				if (i[0] == 1'b0) begin
					sc = sc - tc;
					ss = ss - ts;
				end else begin
					sc = sc + tc;
					ss = ss + ts;
				end
			end
			cq = q62_to_q15(sc);
			sq = q62_to_q15(ss);
		end
		// quadrant folding
		case (q[1:0])
			2'd0: begin
				cv = cq;
				sv = sq;
			end
			2'd1: begin
				cv = -sq;
				sv = cq;
			end
			2'd2: begin
				cv = -cq;
				sv = -sq;
			end
			default: begin
				cv = sq;
				sv = -cq;
			end
		endcase
		return {TW_W'(cv), TW_W'(0 - sv)};
	endfunction

	logic [2*TW_W-1:0] rom [WINDOW_LENGTH];

	// one constant entry per ring position
	for (genvar n = 0; n < WINDOW_LENGTH; n++) begin : g_rom
		localparam logic [2*TW_W-1:0] Entry = twiddle_word(n);
		assign rom[n] = Entry;
	end

	assign {tw_re, tw_im} = rom[pos];

endmodule

// ===== rtl/core/sdft_lane.sv =====
// one channel lane: product ring, twiddle multiply and running sums
module sdft_lane import sdft_pkg::*; #(
	parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int PosW = $clog2(WINDOW_LENGTH)
) (
	input  logic clk,
	input  logic arst_n,
	input  lane_ctrl_t ctrl,
	input  logic [PosW-1:0] pos,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [TW_W-1:0] tw_re,
	input  logic signed [TW_W-1:0] tw_im,
	output logic signed [SUM_W-1:0] real_sum,
	output logic signed [SUM_W-1:0] imag_sum
);

	logic signed [SAMPLE_W-1:0] x;
	logic signed [SUM_W-1:0] prod_re;
	logic signed [SUM_W-1:0] prod_im;
	logic [2*SUM_W-1:0] ring_mem [WINDOW_LENGTH];
	logic [2*SUM_W-1:0] old_s1;
	logic signed [SUM_W-1:0] new_re_s1;
	logic signed [SUM_W-1:0] new_im_s1;
	logic signed [SUM_W-1:0] old_re;
	logic signed [SUM_W-1:0] old_im;
	logic signed [SUM_W-1:0] sum_re_q;
	logic signed [SUM_W-1:0] sum_im_q;

	// sign extend from the active sample width
	assign x = SAMPLE_W'(signed'(sample[SAMPLE_BITS-1:0]));

	// full-width twiddle products
	assign prod_re = tw_re * x;
	assign prod_im = tw_im * x;

	// product ring: old entry read out as the new one goes in
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ring_mem[pos] <= {prod_re, prod_im};
			old_s1 <= ring_mem[pos];
			new_re_s1 <= prod_re;
			new_im_s1 <= prod_im;
		end
	end

	// slots not yet written since the last purge read as zero
	assign old_re = ctrl.filled ? signed'(old_s1[2*SUM_W-1:SUM_W]) : '0;
	assign old_im = ctrl.filled ? signed'(old_s1[SUM_W-1:0]) : '0;

	// running sums, wrapping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
		end else if (ctrl.update) begin
			if (ctrl.clear) begin
				sum_re_q <= '0;
				sum_im_q <= '0;
			end else begin
				sum_re_q <= sum_re_q - old_re + new_re_s1;
				sum_im_q <= sum_im_q - old_im + new_im_s1;
			end
		end
	end

	assign real_sum = sum_re_q;
	assign imag_sum = sum_im_q;

endmodule

// ===== rtl/core/sdft_merge.sv =====
// merging stage: l1 magnitudes of all lanes into the output register
module sdft_merge import sdft_pkg::*; (
	input  logic clk,
	input  logic load,
	input  logic signed [SUM_W-1:0] real_sum [MAX_CHANNELS],
	input  logic signed [SUM_W-1:0] imag_sum [MAX_CHANNELS],
	output result_t result
);

	logic [MAG_W-1:0] mag [MAX_CHANNELS];
	result_t result_d;

	// absolute value, one bit wider so that the most negative value fits
	function automatic logic [MAG_W-1:0] abs_ext(input logic [SUM_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[SUM_W-1], v};
		return ext[MAG_W-1] ? (~ext + 1'b1) : ext;
	endfunction

	// per-lane magnitude
	for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_mag
		assign mag[c] = abs_ext(real_sum[c]) + abs_ext(imag_sum[c]);
	end

	// gather lanes into one transaction
	always_comb begin
		result_d.real_0 = real_sum[0];
		result_d.real_1 = real_sum[1];
		result_d.real_2 = real_sum[2];
		result_d.real_3 = real_sum[3];
		result_d.imag_0 = imag_sum[0];
		result_d.imag_1 = imag_sum[1];
		result_d.imag_2 = imag_sum[2];
		result_d.imag_3 = imag_sum[3];
		result_d.magnitude_0 = mag[0];
		result_d.magnitude_1 = mag[1];
		result_d.magnitude_2 = mag[2];
		result_d.magnitude_3 = mag[3];
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			result <= result_d;
		end
	end

endmodule

// ===== rtl/core/sdft_checker.sv =====
// port-level checks of the sliding dft, bound to the top level
module sdft_checker import sdft_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_stall,
	input sample_t sample,
	input logic result_valid,
	input logic result_stall,
	input result_t result
);

	// nothing leaves the output register while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result valid during reset");

	// input never stalls while the output register is empty
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("sample stalled with empty output");

	// an accepted transaction leads to a valid output once it has passed stage 1 and the sums
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> ##2 result_valid)
		else $error("result missing after accepted sample");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// a stalled sample transaction holds
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample))
		else $error("stalled sample changed");

endmodule

bind sliding_dft_single_bin sdft_checker u_checker (.*);

// ===== tb/sv/sliding_dft_checker.sv =====
// checker for the single-bin sliding dft: predicts every result and compares it
module sliding_dft_checker import sdft_pkg::*; #(
	parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
	parameter int BIN_INDEX = DEF_BIN_INDEX,
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	input  logic sample_stall,
	input  sample_t sample,
	input  logic result_valid,
	input  logic result_stall,
	input  result_t result,
	output int fail_count,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
	localparam int SIGN_LIMIT = 1 << (SAMPLE_BITS - 1);
	localparam int FULL_RANGE = 1 << SAMPLE_BITS;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'(FULL_RANGE - 1);
	localparam int FIELD_COUNT = 3 * MAX_CHANNELS;
	localparam int REPORT_LIMIT = 10;

	// twiddle table and window state
	int twiddle_re [WINDOW_LENGTH];
	int twiddle_im [WINDOW_LENGTH];
	logic [SUM_W-1:0] re_products [WINDOW_LENGTH][MAX_CHANNELS];
	logic [SUM_W-1:0] im_products [WINDOW_LENGTH][MAX_CHANNELS];
	logic [SUM_W-1:0] re_sums [MAX_CHANNELS];
	logic [SUM_W-1:0] im_sums [MAX_CHANNELS];
	int ring_pos;

	result_t expected_results [$];
	result_t predicted;
	result_t oldest;
	int result_index;

	string field_names [FIELD_COUNT] = '{
		"real_0", "real_1", "real_2", "real_3",
		"imag_0", "imag_1", "imag_2", "imag_3",
		"magnitude_0", "magnitude_1", "magnitude_2", "magnitude_3"
	};

	// q62 product, bits 125..62 of the full product
	function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// trunc(32767 * v) for v in q62, clamped to 32767
	function automatic int q62_to_q15(logic [63:0] v);
		logic [63:0] h;
		logic [63:0] l;
		logic [63:0] r;
		h = v >> 31;
		l = v & 64'h7FFF_FFFF;
		r = (h * 64'd32767 + ((l * 64'd32767) >> 31)) >> 31;
		return (r > 64'd32767) ? 32767 : int'(r);
	endfunction

	// taylor series for cos and sin in q62, theta in the first quadrant
	function automatic void q62_cos_sin(input logic [63:0] theta, output logic [63:0] c,
			output logic [63:0] s);
		logic [63:0] t2;
		logic [63:0] tc;
		logic [63:0] ts;
		t2 = q62_mul(theta, theta);
		tc = Q62_ONE;
		ts = theta;
		c = Q62_ONE;
		s = theta;
		for (int i = 1; i <= 14; i++) begin
			tc = q62_mul(tc, t2) / 64'((2 * i - 1) * (2 * i));
			ts = q62_mul(ts, t2) / 64'((2 * i) * (2 * i + 1));
			if (i % 2 == 1) begin
				c = c - tc;
				s = s - ts;
			end else begin
				c = c + tc;
				s = s + ts;
			end
		end
	endfunction

	// twiddle words of every ring position, folded from the first quadrant
	initial begin : build_twiddles
		int m;
		int quadrant;
		int rem;
		int cq;
		int sq;
		int cv;
		int sv;
		logic [63:0] theta;
		logic [63:0] cos_q62;
		logic [63:0] sin_q62;
		for (int n = 0; n < WINDOW_LENGTH; n++) begin
			m = int'((longint'(n) * BIN_INDEX) % WINDOW_LENGTH);
			quadrant = (4 * m) / WINDOW_LENGTH;
			rem = (4 * m) % WINDOW_LENGTH;
			if (rem == 0) begin
				cq = 32767;
				sq = 0;
			end else begin
				theta = (HALF_PI_Q62 / 64'(WINDOW_LENGTH)) * 64'(rem)
					+ ((HALF_PI_Q62 % 64'(WINDOW_LENGTH)) * 64'(rem)) / 64'(WINDOW_LENGTH);
				q62_cos_sin(theta, cos_q62, sin_q62);
				cq = q62_to_q15(cos_q62);
				sq = q62_to_q15(sin_q62);
			end
			case (quadrant % 4)
				0: begin
					cv = cq;
					sv = sq;
				end
				1: begin
					cv = -sq;
					sv = cq;
				end
				2: begin
					cv = -cq;
					sv = -sq;
				end
				default: begin
					cv = sq;
					sv = -cq;
				end
			endcase
			twiddle_re[n] = cv;
			twiddle_im[n] = -sv;
		end
	end

	// purge: sums, product rings and ring position back to zero
	function automatic void clear_window();
		for (int n = 0; n < WINDOW_LENGTH; n++) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				re_products[n][c] = '0;
				im_products[n][c] = '0;
			end
		end
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			re_sums[c] = '0;
			im_sums[c] = '0;
		end
		ring_pos = 0;
	endfunction

	function automatic logic [MAG_W-1:0] abs_wide(logic [SUM_W-1:0] u);
		logic [SUM_W-1:0] neg;
		neg = -u;
		return u[SUM_W-1] ? {1'b0, neg} : {1'b0, u};
	endfunction

	// one step of the sliding dft: expected result of one sample transaction
	function automatic result_t slide_window(sample_t item);
		logic [SAMPLE_W-1:0] raw [MAX_CHANNELS];
		logic [SUM_W-1:0] re_out [MAX_CHANNELS];
		logic [SUM_W-1:0] im_out [MAX_CHANNELS];
		logic [MAG_W-1:0] mag_out [MAX_CHANNELS];
		logic [SUM_W-1:0] re_p;
		logic [SUM_W-1:0] im_p;
		result_t res;
		int x;
		raw[0] = item.sample_0;
		raw[1] = item.sample_1;
		raw[2] = item.sample_2;
		raw[3] = item.sample_3;
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			re_out[c] = '0;
			im_out[c] = '0;
			mag_out[c] = '0;
		end
		if (item.command == CMD_PURGE) begin
			clear_window();
		end else begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				// sign extend from the top sample bit in use
				x = int'(raw[c] & SAMPLE_MASK);
				if (x >= SIGN_LIMIT) begin
					x = x - FULL_RANGE;
				end
				re_p = SUM_W'(twiddle_re[ring_pos] * x);
				im_p = SUM_W'(twiddle_im[ring_pos] * x);
				re_sums[c] = re_sums[c] - re_products[ring_pos][c] + re_p;
				im_sums[c] = im_sums[c] - im_products[ring_pos][c] + im_p;
				re_products[ring_pos][c] = re_p;
				im_products[ring_pos][c] = im_p;
				re_out[c] = re_sums[c];
				im_out[c] = im_sums[c];
				mag_out[c] = abs_wide(re_sums[c]) + abs_wide(im_sums[c]);
			end
			ring_pos = (ring_pos + 1) % WINDOW_LENGTH;
		end
		res.real_0 = re_out[0];
		res.real_1 = re_out[1];
		res.real_2 = re_out[2];
		res.real_3 = re_out[3];
		res.imag_0 = im_out[0];
		res.imag_1 = im_out[1];
		res.imag_2 = im_out[2];
		res.imag_3 = im_out[3];
		res.magnitude_0 = mag_out[0];
		res.magnitude_1 = mag_out[1];
		res.magnitude_2 = mag_out[2];
		res.magnitude_3 = mag_out[3];
		return res;
	endfunction

	function automatic logic [MAG_W-1:0] field_of(result_t r, int i);
		case (i)
			0: return {1'b0, r.real_0};
			1: return {1'b0, r.real_1};
			2: return {1'b0, r.real_2};
			3: return {1'b0, r.real_3};
			4: return {1'b0, r.imag_0};
			5: return {1'b0, r.imag_1};
			6: return {1'b0, r.imag_2};
			7: return {1'b0, r.imag_3};
			8: return r.magnitude_0;
			9: return r.magnitude_1;
			10: return r.magnitude_2;
			default: return r.magnitude_3;
		endcase
	endfunction

	// predict on every accepted sample, compare every accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_window();
			expected_results.delete();
			fail_count = 0;
			result_index = 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				predicted = slide_window(sample);
				expected_results.push_back(predicted);
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < REPORT_LIMIT) begin
						$display("%0t: result transaction %0d arrived with nothing expected",
							$time, result_index);
					end
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					for (int f = 0; f < FIELD_COUNT; f++) begin
						if (field_of(result, f) !== field_of(oldest, f)) begin
							if (fail_count < REPORT_LIMIT) begin
								$display("%0t: result %0d field %s expected %h got %h", $time,
									result_index, field_names[f], field_of(oldest, f),
									field_of(result, f));
							end
							fail_count++;
						end
					end
				end
				result_index++;
			end
		end
		outstanding <= expected_results.size();
	end

endmodule

// ===== tb/sv/sliding_dft_single_bin_test.sv =====
// top of the single-bin sliding dft testbench: clock, reset, stimulus and verdict
module sliding_dft_single_bin_test import sdft_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_LENGTH = DEF_WINDOW_LENGTH;
	localparam int BIN_INDEX = DEF_BIN_INDEX;
	localparam int NUM_CHANNELS = DEF_NUM_CHANNELS;
	localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
	localparam real TWO_PI = 6.283185307179586;
	localparam int PHASE_ITEMS = 400;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	int fail_count;
	int outstanding;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int sent;

	sliding_dft_single_bin #(
		.WINDOW_LENGTH(WINDOW_LENGTH),
		.BIN_INDEX(BIN_INDEX),
		.NUM_CHANNELS(NUM_CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	sliding_dft_checker #(
		.WINDOW_LENGTH(WINDOW_LENGTH),
		.BIN_INDEX(BIN_INDEX),
		.NUM_CHANNELS(NUM_CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// one sample transaction, with random idle cycles ahead of it
	task automatic push_sample(input sample_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= item;
		@(posedge clk);
		while (sample_stall) begin
			@(posedge clk);
		end
		sent++;
	endtask

	task automatic push_fields(input logic cmd, input logic [SAMPLE_W-1:0] s0,
			input logic [SAMPLE_W-1:0] s1, input logic [SAMPLE_W-1:0] s2,
			input logic [SAMPLE_W-1:0] s3);
		sample_t item;
		item.command = cmd;
		item.sample_0 = s0;
		item.sample_1 = s1;
		item.sample_2 = s2;
		item.sample_3 = s3;
		push_sample(item);
	endtask

	// hold the sender until every expected result has come back
	task automatic wait_for_drain();
		int guard;
		guard = 0;
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] to_sample(real v);
		if (v >= 32767.0) begin
			return 16'sd32767;
		end
		if (v <= -32768.0) begin
			return 16'h8000;
		end
		return SAMPLE_W'(int'(v));
	endfunction

	// burst of a tone at the bin frequency, so the sums grow and wrap
	task automatic send_tone_burst(input int len);
		real amp;
		real phase;
		real v [MAX_CHANNELS];
		bit square;
		int noise;
		amp = ($urandom_range(1) == 1) ? real'($urandom_range(32767, 30000))
			: real'($urandom_range(30000, 50));
		phase = real'($urandom_range(6283)) / 1000.0;
		square = ($urandom_range(3) == 0);
		noise = $urandom_range(200);
		for (int n = 0; n < len; n++) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				v[c] = $cos(TWO_PI * BIN_INDEX * n / WINDOW_LENGTH + phase + 0.7 * c);
				if (square) begin
					v[c] = (v[c] >= 0.0) ? amp : -amp - 1.0;
				end else begin
					v[c] = amp * v[c] * (1.0 - 0.15 * c);
				end
				v[c] = v[c] + real'($urandom_range(2 * noise)) - real'(noise);
			end
			push_fields(CMD_SAMPLE, to_sample(v[0]), to_sample(v[1]), to_sample(v[2]),
				to_sample(v[3]));
		end
	endtask

	// random mix: mostly tone bursts, some raw noise and purges
	task automatic run_phase(input int items, input int idle_pct, input int recv_pct);
		int start;
		int pick;
		send_idle_pct = idle_pct;
		stall_pct = recv_pct;
		start = sent;
		while (sent - start < items) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_tone_burst($urandom_range(160, 8));
			end else if (pick < 92) begin
				repeat ($urandom_range(12, 1)) begin
					push_fields(CMD_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
				end
			end else begin
				repeat ($urandom_range(2, 1)) begin
					push_fields(CMD_PURGE, 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
				end
			end
		end
		wait_for_drain();
	endtask

	initial begin
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after a purge these five samples take channel 0 to the most negative real sum
		// and channel 1 to plus two to the 31, which wraps to the same value
		push_fields(CMD_PURGE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_fields(CMD_SAMPLE, -16'sd31072, 16'sd31072, 16'sd32767, 16'h8000);
		push_fields(CMD_SAMPLE, -16'sd4800, 16'sd4800, 16'h0000, 16'h0001);
		push_fields(CMD_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF, 16'h5555);
		push_fields(CMD_SAMPLE, 16'h0000, 16'h0000, 16'hAAAA, 16'h0000);
		push_fields(CMD_SAMPLE, 16'sd31072, -16'sd31072, 16'sd32767, 16'h8000);

		// purge carrying nonzero samples, twice in a row
		push_fields(CMD_PURGE, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h5555);
		push_fields(CMD_PURGE, 16'hAAAA, 16'h0001, 16'h7FFF, 16'h8000);

		// field extremes
		push_fields(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		push_fields(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		push_fields(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_fields(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_fields(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		push_fields(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		push_fields(CMD_SAMPLE, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE);
		push_fields(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		push_fields(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		push_fields(CMD_SAMPLE, 16'h0001, 16'hFFFF, 16'h4000, 16'hC000);
		wait_for_drain();

		// random part, one idling mode per phase
		run_phase(PHASE_ITEMS, 0, 0);
		run_phase(PHASE_ITEMS, 59, 0);
		run_phase(PHASE_ITEMS, 0, 59);
		run_phase(PHASE_ITEMS, 32, 32);

		stall_pct = 0;
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (outstanding != 0) begin
			$display("%0d expected results never arrived", outstanding);
		end
		if (fail_count == 0 && outstanding == 0) begin
			$display("sliding_dft_single_bin_test: PASS");
		end else begin
			$display("sliding_dft_single_bin_test: FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("sliding_dft_single_bin_test: FAIL");
		$finish;
	end

endmodule
